### rtl/inverse_affine_vertex_transform_core_assert.svh
// assertion macros for the inverse affine vertex transform core
// expects signals named clock and reset in the including module
`ifndef INVERSE_AFFINE_VERTEX_TRANSFORM_CORE_ASSERT_SVH
`define INVERSE_AFFINE_VERTEX_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define IAVT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IAVT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/iavt_pkg.sv
// shared constants and types for the inverse affine vertex transform core
// no dependencies
package iavt_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int MATRIX_WIDTH    = 21;
   localparam int TRANS_WIDTH     = 32;
   localparam int INV_WIDTH       = 32;
   localparam int INV_ENTRIES     = 9;
   localparam int DIV_SHIFT       = 36;
   localparam int FRAC_SHIFT      = 20;
   localparam int ONE_Q4_16       = 65536;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_ROW0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_ROW1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_ROW2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRANS_XY    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRANS_Z     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADJ  = 4'b0010,
      ST_DET  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

endpackage

### rtl/inverse_affine_vertex_transform_core.sv
// inverse affine vertex transform: requests pass through a four stage valid/stall
// pipeline at one request per cycle while neither rsp_stall nor the inverse rebuild
// holds it; after reset and after every matrix row write the inverse is rebuilt by a
// sequencer (adjugate, determinant, bit-serial divider, one entry at a time),
// with req_stall high meanwhile
// reset is synchronous active high; depends on iavt_pkg and the assert header
`include "inverse_affine_vertex_transform_core_assert.svh"

module inverse_affine_vertex_transform_core #(
   parameter int COORD_WIDTH  = iavt_pkg::COORD_WIDTH,
   parameter int MATRIX_WIDTH = iavt_pkg::MATRIX_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0]          req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0]          req_vertex_z,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_WIDTH-1:0]          rsp_local_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_local_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_local_z,
   output logic                                   rsp_singular,
   output logic                                   rsp_saturated,
   output logic                                   rsp_last_out,
   input  logic                                   csr_we,
   input  logic [iavt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [iavt_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int MW    = MATRIX_WIDTH;
   localparam int TW    = iavt_pkg::TRANS_WIDTH;
   localparam int IW    = iavt_pkg::INV_WIDTH;
   localparam int NE    = iavt_pkg::INV_ENTRIES;
   localparam int FR    = iavt_pkg::FRAC_SHIFT;
   localparam int DW    = ((CW > TW) ? CW : TW) + 1;
   localparam int PW    = DW + IW;
   localparam int SW    = PW + 2;
   localparam int RW    = 3 * MW;
   localparam int PRW   = 2 * MW;
   localparam int ADJ_W = PRW + 1;
   localparam int DPW   = MW + ADJ_W;
   localparam int DET_W = DPW + 2;
   localparam int NB    = ADJ_W + iavt_pkg::DIV_SHIFT;
   localparam int CNT_W = $clog2(NB + 2);

   localparam logic [MW-1:0]          ONE_Q    = MW'(iavt_pkg::ONE_Q4_16);
   localparam logic [RW-1:0]          ONE_ROW  = RW'(ONE_Q);
   localparam logic signed [SW-1:0]   ROUND_C  = SW'(1) << (FR - 1);
   localparam logic signed [SW-1:0]   HI_C     = SW'({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [SW-1:0]   LO_C     = ~HI_C;
   localparam logic [IW:0]            LIM_POS  = {2'b00, {(IW-1){1'b1}}};
   localparam logic [IW:0]            LIM_NEG  = {2'b01, {(IW-1){1'b0}}};

   // ---------------- configuration ----------------
   logic [RW-1:0]         row_ff [3];
   logic [2*TW-1:0]       txy_ff;
   logic [TW-1:0]         tz_ff;
   logic                  mrow_wr;

   assign mrow_wr = csr_we && (csr_index inside {iavt_pkg::CSR_MATRIX_ROW0,
                                                 iavt_pkg::CSR_MATRIX_ROW1,
                                                 iavt_pkg::CSR_MATRIX_ROW2});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            row_ff[r] <= ONE_ROW << (r * MW);
         end
         txy_ff <= '0;
         tz_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            iavt_pkg::CSR_MATRIX_ROW0: row_ff[0] <= csr_wdata[RW-1:0];
            iavt_pkg::CSR_MATRIX_ROW1: row_ff[1] <= csr_wdata[RW-1:0];
            iavt_pkg::CSR_MATRIX_ROW2: row_ff[2] <= csr_wdata[RW-1:0];
            iavt_pkg::CSR_TRANS_XY:    txy_ff    <= csr_wdata[2*TW-1:0];
            iavt_pkg::CSR_TRANS_Z:     tz_ff     <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   logic signed [MW-1:0] m_fld [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            m_fld[r][c] = row_ff[r][c*MW +: MW];
         end
      end
   end

   // ---------------- inverse sequencer ----------------
   iavt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [3:0]           ent_ff, ent_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic                 dvld_ff, dvld_in;

   logic signed [PRW-1:0]   pa_ff, pb_ff;
   logic signed [ADJ_W-1:0] adj_ff [NE];
   logic signed [DPW-1:0]   dprod_ff;
   logic signed [DET_W-1:0] det_ff, det_nx;
   logic [DET_W-1:0]        dd_ff;
   logic                    detneg_ff;
   logic [DET_W-1:0]        rem_ff;
   logic [NB-1:0]           num_ff;
   logic [IW:0]             q_ff;
   logic                    big_ff;
   logic                    neg_ff;
   logic signed [IW-1:0]    inv_ff [NE];
   logic                    singular_ff;
   logic                    clipped_ff;

   logic signed [MW-1:0] opa, opb, opc, opd, m0sel;

   always_comb begin
      opa = '0;
      opb = '0;
      opc = '0;
      opd = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (cnt_ff[3:0] == 4'(r * 3 + c)) begin
               opa = m_fld[(c+1)%3][(r+1)%3];
               opb = m_fld[(c+2)%3][(r+2)%3];
               opc = m_fld[(c+1)%3][(r+2)%3];
               opd = m_fld[(c+2)%3][(r+1)%3];
            end
         end
      end
      m0sel = '0;
      for (int c = 0; c < 3; c++) begin
         if (cnt_ff[1:0] == 2'(c)) begin
            m0sel = m_fld[0][c];
         end
      end
   end

   logic adj_issue, det_last, div_load, div_step, div_write;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ent_in      = ent_ff;
      prod_vld_in = 1'b0;
      dvld_in     = 1'b0;
      adj_issue   = 1'b0;
      det_last    = 1'b0;
      div_load    = 1'b0;
      div_step    = 1'b0;
      div_write   = 1'b0;
      case (state_ff)
         iavt_pkg::ST_IDLE: ;
         iavt_pkg::ST_ADJ: begin
            if (cnt_ff == CNT_W'(NE)) begin
               state_in = iavt_pkg::ST_DET;
               cnt_in   = '0;
            end else begin
               adj_issue   = 1'b1;
               prod_vld_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         iavt_pkg::ST_DET: begin
            if (cnt_ff == CNT_W'(3)) begin
               det_last = 1'b1;
               state_in = iavt_pkg::ST_DIV;
               cnt_in   = '0;
               ent_in   = '0;
            end else begin
               dvld_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         iavt_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               div_load = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end else if (cnt_ff == CNT_W'(NB + 1)) begin
               div_write = 1'b1;
               cnt_in    = '0;
               ent_in    = ent_ff + 1'b1;
               if (ent_ff == 4'(NE - 1)) begin
                  state_in = iavt_pkg::ST_IDLE;
               end
            end else begin
               div_step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         default: state_in = iavt_pkg::ST_IDLE;
      endcase
      // a row write restarts the rebuild from the adjugate
      if (mrow_wr) begin
         state_in    = iavt_pkg::ST_ADJ;
         cnt_in      = '0;
         ent_in      = '0;
         prod_vld_in = 1'b0;
         dvld_in     = 1'b0;
         adj_issue   = 1'b0;
         det_last    = 1'b0;
         div_load    = 1'b0;
         div_step    = 1'b0;
         div_write   = 1'b0;
      end
   end

   assign det_nx = det_ff + DET_W'(dprod_ff);

   // divider datapath
   logic [DET_W:0]       rem_sh;
   logic                 rem_ge;
   logic                 big_f;
   logic                 clip_f;
   logic [IW:0]          lim;
   logic [IW:0]          qv;
   logic signed [IW-1:0] inv_val;
   logic [ADJ_W-1:0]     adj_abs;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NB-1]};
      rem_ge  = rem_sh >= {1'b0, dd_ff};
      big_f   = big_ff | q_ff[IW];
      lim     = neg_ff ? LIM_NEG : LIM_POS;
      clip_f  = !singular_ff && (big_f || (q_ff > lim));
      qv      = (big_f || (q_ff > lim)) ? lim : q_ff;
      inv_val = singular_ff ? '0 : IW'(neg_ff ? (~qv + 1'b1) : qv);
      adj_abs = adj_ff[0][ADJ_W-1] ? ADJ_W'(-adj_ff[0]) : ADJ_W'(adj_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= iavt_pkg::ST_ADJ;
         cnt_ff      <= '0;
         ent_ff      <= '0;
         prod_vld_ff <= 1'b0;
         dvld_ff     <= 1'b0;
         singular_ff <= 1'b0;
         clipped_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ent_ff      <= ent_in;
         prod_vld_ff <= prod_vld_in;
         dvld_ff     <= dvld_in;
         if (det_last) begin
            singular_ff <= (det_nx == '0);
            clipped_ff  <= 1'b0;
         end else if (div_write) begin
            clipped_ff <= clipped_ff | clip_f;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adj_issue) begin
         pa_ff <= PRW'(opa) * PRW'(opb);
         pb_ff <= PRW'(opc) * PRW'(opd);
      end
      if (state_ff == iavt_pkg::ST_ADJ && prod_vld_ff && !mrow_wr) begin
         for (int k = 0; k < NE - 1; k++) begin
            adj_ff[k] <= adj_ff[k+1];
         end
         adj_ff[NE-1] <= ADJ_W'(pa_ff) - ADJ_W'(pb_ff);
      end else if (dvld_in) begin
         // step by one column of the first row
         for (int k = 0; k < NE; k++) begin
            adj_ff[k] <= adj_ff[(k+3)%NE];
         end
      end else if (div_write) begin
         for (int k = 0; k < NE; k++) begin
            adj_ff[k] <= adj_ff[(k+1)%NE];
         end
      end
      if (dvld_in) begin
         dprod_ff <= DPW'(m0sel) * DPW'(adj_ff[0]);
      end
      if (state_ff == iavt_pkg::ST_ADJ) begin
         det_ff <= '0;
      end else if (dvld_ff) begin
         det_ff <= det_nx;
      end
      if (det_last) begin
         dd_ff     <= det_nx[DET_W-1] ? DET_W'(-det_nx) : DET_W'(det_nx);
         detneg_ff <= det_nx[DET_W-1];
      end
      if (div_load) begin
         rem_ff <= '0;
         num_ff <= {adj_abs, {iavt_pkg::DIV_SHIFT{1'b0}}};
         q_ff   <= '0;
         big_ff <= 1'b0;
         neg_ff <= adj_ff[0][ADJ_W-1] ^ detneg_ff;
      end else if (div_step) begin
         rem_ff <= rem_ge ? DET_W'(rem_sh - {1'b0, dd_ff}) : DET_W'(rem_sh);
         num_ff <= num_ff << 1;
         q_ff   <= {q_ff[IW-1:0], rem_ge};
         big_ff <= big_f;
      end
      if (div_write) begin
         for (int k = 0; k < NE - 1; k++) begin
            inv_ff[k] <= inv_ff[k+1];
         end
         inv_ff[NE-1] <= inv_val;
      end
   end

   // ---------------- vertex pipeline ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic req_take;

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = (state_ff != iavt_pkg::ST_IDLE) || !rdy1;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_take;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   logic signed [TW-1:0] tx, ty, tz;
   assign tx = txy_ff[TW-1:0];
   assign ty = txy_ff[2*TW-1:TW];
   assign tz = tz_ff;

   logic signed [DW-1:0] d1_ff [3];
   logic                 last1_ff, last2_ff, last3_ff;
   logic signed [PW-1:0] p2_ff [NE];
   logic signed [SW-1:0] s3_ff [3];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         d1_ff[0] <= DW'(req_vertex_x) - DW'(tx);
         d1_ff[1] <= DW'(req_vertex_y) - DW'(ty);
         d1_ff[2] <= DW'(req_vertex_z) - DW'(tz);
         last1_ff <= req_last_vertex;
      end
      if (rdy2) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               p2_ff[r*3+c] <= PW'(d1_ff[r]) * PW'(inv_ff[r*3+c]);
            end
         end
         last2_ff <= last1_ff;
      end
      if (rdy3) begin
         for (int c = 0; c < 3; c++) begin
            s3_ff[c] <= SW'(p2_ff[c]) + SW'(p2_ff[3+c]) + SW'(p2_ff[6+c]) + ROUND_C;
         end
         last3_ff <= last2_ff;
      end
   end

   // round by floor shift, then clip to the coordinate range
   logic signed [SW-1:0] sh [3];
   logic signed [CW-1:0] cl [3];
   logic [2:0]           sat_c;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sh[c]    = s3_ff[c] >>> FR;
         sat_c[c] = (sh[c] > HI_C) || (sh[c] < LO_C);
         if (sh[c] > HI_C) begin
            cl[c] = CW'(HI_C);
         end else if (sh[c] < LO_C) begin
            cl[c] = CW'(LO_C);
         end else begin
            cl[c] = CW'(sh[c]);
         end
      end
   end

   logic signed [CW-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                 out_sing_ff, out_sat_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out_x_ff    <= singular_ff ? '0 : cl[0];
         out_y_ff    <= singular_ff ? '0 : cl[1];
         out_z_ff    <= singular_ff ? '0 : cl[2];
         out_sing_ff <= singular_ff;
         out_sat_ff  <= !singular_ff && (clipped_ff || (|sat_c));
         out_last_ff <= last3_ff;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_local_x   = out_x_ff;
   assign rsp_local_y   = out_y_ff;
   assign rsp_local_z   = out_z_ff;
   assign rsp_singular  = out_sing_ff;
   assign rsp_saturated = out_sat_ff;
   assign rsp_last_out  = out_last_ff;

   `IAVT_ASSERT_NXT(a_row_restart, mrow_wr, (state_ff == iavt_pkg::ST_ADJ) && (cnt_ff == '0), "matrix write did not restart the inverse rebuild")
   `IAVT_ASSERT_IMP(a_singular_zero, rsp_valid && rsp_singular, (rsp_local_x == '0) && (rsp_local_y == '0) && (rsp_local_z == '0) && !rsp_saturated, "singular result carries data")
   `IAVT_ASSERT_NXT(a_req_enters, req_take, v1_ff, "accepted request missing from first stage")
   `IAVT_ASSERT_IMP(a_inverse_stable, (state_ff == iavt_pkg::ST_IDLE) && $past(state_ff == iavt_pkg::ST_IDLE), $stable(singular_ff) && $stable(clipped_ff), "inverse flags changed while idle")

endmodule
